@@ rtl/idl_pkg.sv @@
// -----------------------------------------------------------------------------
// Indexed deque list package
// Shared widths, command and status codes, controller states and the
// command/status bundles between controller and datapath.
// -----------------------------------------------------------------------------
package idl_pkg;

   localparam int OPCODE_W = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD_FRONT     = 3'd0,
      OP_ADD_REAR      = 3'd1,
      OP_REMOVE_FRONT  = 3'd2,
      OP_REMOVE_REAR   = 3'd3,
      OP_INSERT_BEFORE = 3'd4,
      OP_DELETE_AT     = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_RANGE     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_MOVE   = 2'd1,
      S_FINISH = 2'd2
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // latch and decode the accepted command
      logic move;    // run the element shift
      logic commit;  // place, update count, present the result
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic move_done;  // no more reads to issue
      logic out_free;   // result register can take a new result
   } dp_stat_type;

endpackage

@@ rtl/idl_channels.sv @@
// -----------------------------------------------------------------------------
// Indexed deque list channels
// Valid/ready interfaces for the command channel and the result channel.
// -----------------------------------------------------------------------------
interface idl_req_if import idl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    position;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, output opcode, output position, output value,
                   input ready);
   modport sink (input valid, input opcode, input position, input value,
                 output ready);
endinterface

interface idl_rsp_if import idl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  removed_value;
   logic [STATUS_W-1:0] status;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, output removed_value, output status,
                   output occupancy, input ready);
   modport sink (input valid, input removed_value, input status,
                 input occupancy, output ready);
endinterface

@@ rtl/idl_ram.sv @@
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module idl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/idl_ctrl.sv @@
// -----------------------------------------------------------------------------
// Indexed deque list controller
// Sequences accept, element shift and result commit for one command.
// -----------------------------------------------------------------------------
module idl_ctrl import idl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            if (dp_stat.move_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (dp_stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      dp_cmd.load   = 1'b0;
      dp_cmd.move   = 1'b0;
      dp_cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            dp_cmd.load = req_valid;
         end
         S_MOVE: begin
            dp_cmd.move = 1'b1;
         end
         S_FINISH: begin
            dp_cmd.commit = dp_stat.out_free;
         end
         default: ;
      endcase
   end

endmodule

@@ rtl/idl_dpath.sv @@
// -----------------------------------------------------------------------------
// Indexed deque list datapath
// Command decode, element RAM with shift pipeline, count and result register.
// -----------------------------------------------------------------------------
module idl_dpath import idl_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          dp_cmd,
   output dp_stat_type         dp_stat,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [POS_W-1:0]    req_position,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_removed_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int PW  = (CW > POS_W) ? CW : POS_W;
   localparam int PXW = PW + 1;
   localparam int XW  = (ELEM_WIDTH > VALUE_W) ? ELEM_WIDTH : VALUE_W;

   // ---- command decode ----
   logic [CW-1:0]  count_ff, count_in;
   logic [PXW-1:0] pos_x, cnt_x;
   logic [XW-1:0]  value_x;
   logic           full, empty;
   logic           dec_put, dec_take;
   status_type     dec_status;
   logic [CW-1:0]  dec_idx, dec_rem;
   logic [AW-1:0]  dec_src;

   assign pos_x   = PXW'(req_position);
   assign cnt_x   = PXW'(count_ff);
   assign value_x = XW'(req_value);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);

   always_comb begin
      dec_put    = 1'b0;
      dec_take   = 1'b0;
      dec_status = ST_OK;
      dec_idx    = '0;
      unique case (opcode_type'(req_opcode))
         OP_ADD_FRONT: begin
            if (full) dec_status = ST_FULL;
            else dec_put = 1'b1;
         end
         OP_ADD_REAR: begin
            if (full) dec_status = ST_FULL;
            else begin
               dec_put = 1'b1;
               dec_idx = count_ff;
            end
         end
         OP_REMOVE_FRONT: begin
            if (empty) dec_status = ST_UNDERFLOW;
            else dec_take = 1'b1;
         end
         OP_REMOVE_REAR: begin
            if (empty) dec_status = ST_UNDERFLOW;
            else begin
               dec_take = 1'b1;
               dec_idx  = count_ff - CW'(1);
            end
         end
         OP_INSERT_BEFORE: begin
            if (pos_x == '0 || pos_x > cnt_x + PXW'(1)) dec_status = ST_RANGE;
            else if (full) dec_status = ST_FULL;
            else begin
               dec_put = 1'b1;
               dec_idx = CW'(pos_x - PXW'(1));
            end
         end
         OP_DELETE_AT: begin
            if (pos_x == '0 || pos_x > cnt_x) dec_status = ST_RANGE;
            else begin
               dec_take = 1'b1;
               dec_idx  = CW'(pos_x - PXW'(1));
            end
         end
         default: ;
      endcase
   end

   assign dec_rem = (dec_put || dec_take) ? (count_ff - dec_idx) : '0;
   assign dec_src = dec_put ? AW'(count_ff - CW'(1)) : AW'(dec_idx);

   // ---- command registers and shift pipeline ----
   logic                  put_ff, put_in, take_ff, take_in;
   status_type            status_ff, status_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [ELEM_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic [AW-1:0]         src_ff, src_in;
   logic [AW-1:0]         dst_ff, dst_in;
   logic                  first_ff, first_in;
   logic                  pend_ff, pend_in;
   logic                  pend_first_ff, pend_first_in;
   logic [ELEM_WIDTH-1:0] removed_ff, removed_in;
   logic [XW-1:0]         removed_x;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_removed_ff, rsp_removed_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic                  ram_wr_en, ram_rd_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [ELEM_WIDTH-1:0] ram_wr_data, ram_rd_data;

   assign removed_x = XW'(removed_ff);

   idl_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (src_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      put_in         = put_ff;
      take_in        = take_ff;
      status_in      = status_ff;
      idx_in         = idx_ff;
      val_in         = val_ff;
      rem_in         = rem_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      first_in       = first_ff;
      pend_in        = 1'b0;
      pend_first_in  = pend_first_ff;
      removed_in     = removed_ff;
      count_in       = count_ff;
      ram_rd_en      = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = dst_ff;
      ram_wr_data    = ram_rd_data;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_occ_in     = rsp_occ_ff;

      if (dp_cmd.load) begin
         put_in     = dec_put;
         take_in    = dec_take;
         status_in  = dec_status;
         idx_in     = AW'(dec_idx);
         val_in     = value_x[ELEM_WIDTH-1:0];
         rem_in     = dec_rem;
         src_in     = dec_src;
         first_in   = dec_take;
         removed_in = '0;
      end

      if (dp_cmd.move) begin
         // issue the next read; the data lands one place over next cycle
         if (rem_ff != '0) begin
            ram_rd_en     = 1'b1;
            pend_in       = 1'b1;
            pend_first_in = first_ff;
            first_in      = 1'b0;
            dst_in        = put_ff ? (src_ff + AW'(1)) : (src_ff - AW'(1));
            src_in        = put_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
            rem_in        = rem_ff - CW'(1);
         end
         // first read of a removal is the element taken out
         if (pend_ff) begin
            if (pend_first_ff) removed_in = ram_rd_data;
            else ram_wr_en = 1'b1;
         end
      end

      if (dp_cmd.commit) begin
         if (put_ff) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = val_ff;
            count_in    = count_ff + CW'(1);
         end else if (take_ff) begin
            count_in = count_ff - CW'(1);
         end
         rsp_valid_in   = 1'b1;
         rsp_removed_in = removed_x[VALUE_W-1:0];
         rsp_status_in  = status_ff;
         rsp_occ_in     = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      put_ff         <= put_in;
      take_ff        <= take_in;
      status_ff      <= status_in;
      idx_ff         <= idx_in;
      val_ff         <= val_in;
      rem_ff         <= rem_in;
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      first_ff       <= first_in;
      pend_first_ff  <= pend_first_in;
      removed_ff     <= removed_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign dp_stat.move_done = (rem_ff == '0);
   assign dp_stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_occupancy     = rsp_occ_ff;

endmodule

@@ rtl/indexed_deque_list.sv @@
// -----------------------------------------------------------------------------
// Indexed deque list
// Ordered list of up to DEPTH elements with front/rear add and remove and
// 1-based insert-before / delete-at, one result per command.
// -----------------------------------------------------------------------------
//
//   channel    direction  handshake     payload
//   req_port   in         valid/ready   opcode, position, value
//   rsp_port   out        valid/ready   removed_value, status, occupancy
//
// Reads: n = count - index element RAM reads per command (the removed
//   element and every element that moves one place, 0 when none moves), one
//   read a cycle; a front remove on a full list is the worst, with DEPTH reads.
// Reset: clears the controller, the count and the result register; the
//   element RAM is not cleared and needs no pass.
// Stalls: the next command is accepted while a result waits and holds in its
//   final step until the waiting result is transferred.
//
module indexed_deque_list import idl_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int ELEM_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   idl_req_if.sink   req_port,
   idl_rsp_if.source rsp_port
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequence accept, shift and commit
   idl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   // decode, hold elements, shift and build the result
   idl_dpath #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat),
      .req_opcode        (req_port.opcode),
      .req_position      (req_port.position),
      .req_value         (req_port.value),
      .rsp_valid         (rsp_port.valid),
      .rsp_ready         (rsp_port.ready),
      .rsp_removed_value (rsp_port.removed_value),
      .rsp_status        (rsp_port.status),
      .rsp_occupancy     (rsp_port.occupancy)
   );

endmodule

@@ rtl/idl_check.sv @@
// -----------------------------------------------------------------------------
// Indexed deque list checker
// Port-level checks on command pacing and result consistency, bound to the
// top level.
// -----------------------------------------------------------------------------
module idl_check import idl_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [VALUE_W-1:0]  rsp_removed_value,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [OCC_W-1:0]    rsp_occupancy
);

   // no result left over from before reset
   a_reset_clears: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // one command in work at a time: ready drops after each transfer
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while another is in work");

   // underflow only on an empty list
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_UNDERFLOW |-> rsp_occupancy == '0)
      else $error("underflow with elements held");

   // full only with every entry held
   a_full_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> int'(rsp_occupancy) == (DEPTH % 32))
      else $error("full reported below capacity");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_removed_value)
         && $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("stalled result changed");

endmodule

bind indexed_deque_list idl_check #(.DEPTH(DEPTH)) u_idl_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_port.valid),
   .req_ready         (req_port.ready),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_removed_value (rsp_port.removed_value),
   .rsp_status        (rsp_port.status),
   .rsp_occupancy     (rsp_port.occupancy)
);
